[hdl/bbd_pkg.sv]
// Shared types, constants and helpers for the bilinear Bayer demosaic block.
// Used by every module under hdl/; has no dependencies of its own.
`default_nettype none
package bbd_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 4096;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;

	localparam int unsigned PIX_W     = 8;
	localparam int unsigned CFG_W     = 13;
	localparam int unsigned REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] RESET_DIM = 13'd256;
	localparam int unsigned MIN_DIM = 3;

	// Result buffer depth; three entries keep one item per cycle, while the output
	// accepts, with no combinational path from the output ready to the input ready.
	localparam int unsigned OUT_FIFO_DEPTH = 3;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_STEADY
	} row_phase_t;

	// Position flags of one window, produced at the input side.
	typedef struct packed {
		logic lag;
		logic eof;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic row_odd;
		logic col_odd;
	} pos_ctl_t;

	typedef struct packed {
		logic             eof;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgb_item_t;

	// Clamps a dimension register to [MIN_DIM, hi] and returns the value minus one.
	function automatic int unsigned dim_last(input logic [CFG_W-1:0] v, input int unsigned hi);
		int unsigned d;
		d = 32'(v);
		if (d < MIN_DIM) begin
			d = MIN_DIM;
		end else if (d > hi) begin
			d = hi;
		end
		return d - 1;
	endfunction

endpackage
`default_nettype wire

[hdl/bbd_line_store.sv]
// Two-line raw pixel store held in one synchronous memory, entry = {upper, middle}.
// Read-modify-write per column with forwarding; depends on bbd_pkg.
`default_nettype none
module bbd_line_store
	import bbd_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [PIX_W-1:0] wr_pix,
	output logic      [PIX_W-1:0] upper_rd,
	output logic      [PIX_W-1:0] middle_rd
);

	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;

	assign upper_rd  = rd_q[2*PIX_W-1:PIX_W];
	assign middle_rd = rd_q[PIX_W-1:0];

	// The write of a column is issued the cycle after its read; the line moves
	// down by one: the old middle becomes upper and the new sample becomes middle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {middle_rd, wr_pix};
		end
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= {middle_rd, wr_pix};
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

endmodule
`default_nettype wire

[hdl/bbd_window_interp.sv]
// 3x3 raw window with border mirroring and bilinear color reconstruction.
// Depends on bbd_pkg for the position flags and the result type.
`default_nettype none
module bbd_window_interp
	import bbd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             restart,
	input  wire logic             step,
	input  wire pos_ctl_t         ctl,
	input  wire logic [PIX_W-1:0] upper_px,
	input  wire logic [PIX_W-1:0] middle_px,
	input  wire logic [PIX_W-1:0] new_px,
	output rgb_item_t             result
);

	// win_q[row][col]; column 2 is the newest.
	logic [2:0][2:0][PIX_W-1:0] win_q;
	logic [2:0][2:0][PIX_W-1:0] shifted;
	logic [2:0][2:0][PIX_W-1:0] rmir;
	logic [2:0][2:0][PIX_W-1:0] p;
	logic [PIX_W:0]   hz_sum;
	logic [PIX_W:0]   vt_sum;
	logic [PIX_W+1:0] cross_sum;
	logic [PIX_W+1:0] diag_sum;
	logic [PIX_W-1:0] ctr, hz, vt, crs, dg;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			shifted[k][0] = win_q[k][1];
			shifted[k][1] = win_q[k][2];
		end
		shifted[0][2] = upper_px;
		shifted[1][2] = middle_px;
		shifted[2][2] = new_px;

		// Rows are mirrored first, then columns, so corners take the diagonal.
		rmir = shifted;
		if (ctl.top) begin
			rmir[0] = shifted[2];
		end else if (ctl.bottom) begin
			rmir[2] = shifted[0];
		end
		p = rmir;
		for (int k = 0; k < 3; k++) begin
			if (ctl.left) begin
				p[k][0] = rmir[k][2];
			end else if (ctl.right) begin
				p[k][2] = rmir[k][0];
			end
		end
	end

	always_comb begin
		hz_sum    = {1'b0, p[1][0]} + {1'b0, p[1][2]};
		vt_sum    = {1'b0, p[0][1]} + {1'b0, p[2][1]};
		cross_sum = {2'b00, p[0][1]} + {2'b00, p[2][1]} + {2'b00, p[1][0]} + {2'b00, p[1][2]};
		diag_sum  = {2'b00, p[0][0]} + {2'b00, p[0][2]} + {2'b00, p[2][0]} + {2'b00, p[2][2]};
		ctr = p[1][1];
		hz  = hz_sum[PIX_W:1];
		vt  = vt_sum[PIX_W:1];
		crs = cross_sum[PIX_W+1:2];
		dg  = diag_sum[PIX_W+1:2];

		result.eof = ctl.eof;
		unique case ({ctl.row_odd, ctl.col_odd})
			2'b00: begin
				result.green = ctr;
				result.red   = hz;
				result.blue  = vt;
			end
			2'b01: begin
				result.red   = ctr;
				result.green = crs;
				result.blue  = dg;
			end
			2'b10: begin
				result.blue  = ctr;
				result.green = crs;
				result.red   = dg;
			end
			default: begin
				result.green = ctr;
				result.blue  = hz;
				result.red   = vt;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (restart || (step && ctl.eof)) begin
			win_q <= '0;
		end else if (step) begin
			win_q <= shifted;
		end
	end

endmodule
`default_nettype wire

[hdl/bbd_out_fifo.sv]
// Small result buffer between the reconstruction stage and the output stream.
// Depends on bbd_pkg for the result type and depth.
`default_nettype none
module bbd_out_fifo
	import bbd_pkg::*;
#(
	localparam int unsigned PW = $clog2(OUT_FIFO_DEPTH),
	localparam int unsigned CW = $clog2(OUT_FIFO_DEPTH + 1)
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire rgb_item_t push_item,
	input  wire logic      pop_ready,
	output logic           pop_valid,
	output rgb_item_t      pop_item,
	output logic [CW-1:0]  level
);

	rgb_item_t     entry_q [OUT_FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign pop_valid = (cnt_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];
	assign level     = cnt_q;
	assign pop       = pop_valid && pop_ready;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] ptr);
		return (ptr == PW'(OUT_FIFO_DEPTH - 1)) ? '0 : ptr + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/bayer_bilinear_demosaic_core.sv]
// Bilinear demosaic for a GRBG Bayer stream: position control, line store,
// window reconstruction and result buffer. Depends on bbd_pkg and all bbd_* modules.
//
// Usage:
//   Input stream s_axis: tdata = raw sample (8 bits), tuser = 1 marks a flush
//   item (taken as sample 0). Raw samples arrive in raster order; after the
//   width*height samples of a frame send width+1 flush items to drain it.
//   Output stream m_axis: tdata = {blue, green, red}, red in the low byte;
//   tlast marks the last pixel of the frame, after which positions restart.
//   Config port: cfg_we with cfg_index 0 (width) or 1 (height); values are
//   clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT]. A write restarts the frame
//   and must be issued while no transfer is in flight.
//   Throughput is one item per cycle; the line store is read one cycle and
//   written the next, the result is registered from the s1 stage into a
//   three-entry buffer and is presented on m_axis from that buffer.
//   Output lag is one row plus one pixel of input transfers.
//   When m_axis stalls, the buffer absorbs results in flight and s_axis_tready
//   drops once the buffer and the reconstruction stage together are full.
//   Reset sets width and height to 256 and clears positions and the window;
//   the line store is not cleared, its stale entries are always mirrored out.
`default_nettype none
module bayer_bilinear_demosaic_core
	import bbd_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,   // [7:0] raw_value
	input  wire logic                 s_axis_tuser,   // [0] cmd
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic      [23:0]          m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	output logic                      m_axis_tlast    // end_of_frame
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned HW = $clog2(MAX_HEIGHT);
	localparam int unsigned CW = $clog2(OUT_FIFO_DEPTH + 1);

	logic [AW-1:0] w_last_q;
	logic [HW-1:0] h_last_q;

	logic [AW-1:0] in_col_q;
	row_phase_t    phase_q;
	row_phase_t    phase_next;
	logic [AW-1:0] out_col_q;
	logic [HW-1:0] out_row_q;

	logic       accept;
	logic       col_wrap;
	logic       out_col_wrap;
	pos_ctl_t   ctl_now;

	logic             valid_s1;
	pos_ctl_t         ctl_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [AW-1:0]    addr_s1;
	logic [PIX_W-1:0] pix_in;

	logic [PIX_W-1:0] upper_rd;
	logic [PIX_W-1:0] middle_rd;
	rgb_item_t        result_s1;
	rgb_item_t        out_item;
	logic [CW-1:0]    fifo_level;
	logic [CW:0]      credit_used;
	logic             pend_s1;

	// Results either in the buffer or one stage away must fit in the buffer.
	assign pend_s1       = valid_s1 && ctl_s1.lag;
	assign credit_used   = (CW + 1)'(fifo_level) + (CW + 1)'(pend_s1);
	assign s_axis_tready = (credit_used < (CW + 1)'(OUT_FIFO_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pix_in        = s_axis_tuser ? '0 : s_axis_tdata;

	always_comb begin
		col_wrap     = (in_col_q == w_last_q);
		out_col_wrap = (out_col_q == w_last_q);

		ctl_now.lag     = (phase_q == PH_STEADY) || ((phase_q == PH_SECOND) && (in_col_q != '0));
		ctl_now.top     = (out_row_q == '0);
		ctl_now.bottom  = (out_row_q == h_last_q);
		ctl_now.left    = (out_col_q == '0);
		ctl_now.right   = out_col_wrap;
		ctl_now.row_odd = out_row_q[0];
		ctl_now.col_odd = out_col_q[0];
		ctl_now.eof     = ctl_now.lag && ctl_now.bottom && out_col_wrap;

		unique case (phase_q)
			PH_FIRST:  phase_next = col_wrap ? PH_SECOND : PH_FIRST;
			PH_SECOND: phase_next = col_wrap ? PH_STEADY : PH_SECOND;
			default:   phase_next = PH_STEADY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= AW'(dim_last(RESET_DIM, MAX_WIDTH));
			h_last_q <= HW'(dim_last(RESET_DIM, MAX_HEIGHT));
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  w_last_q <= AW'(dim_last(cfg_data, MAX_WIDTH));
				REG_IMAGE_HEIGHT: h_last_q <= HW'(dim_last(cfg_data, MAX_HEIGHT));
				default:          w_last_q <= w_last_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			phase_q   <= PH_FIRST;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we || (accept && ctl_now.eof)) begin
			in_col_q  <= '0;
			phase_q   <= PH_FIRST;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			in_col_q <= col_wrap ? '0 : in_col_q + AW'(1);
			phase_q  <= phase_next;
			if (ctl_now.lag) begin
				out_col_q <= out_col_wrap ? '0 : out_col_q + AW'(1);
				if (out_col_wrap) begin
					out_row_q <= out_row_q + HW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1  <= ctl_now;
			pix_s1  <= pix_in;
			addr_s1 <= in_col_q;
		end
	end

	bbd_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (in_col_q),
		.wr_en     (valid_s1),
		.wr_addr   (addr_s1),
		.wr_pix    (pix_s1),
		.upper_rd  (upper_rd),
		.middle_rd (middle_rd)
	);

	bbd_window_interp u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_we),
		.step      (valid_s1),
		.ctl       (ctl_s1),
		.upper_px  (upper_rd),
		.middle_px (middle_rd),
		.new_px    (pix_s1),
		.result    (result_s1)
	);

	bbd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pend_s1),
		.push_item (result_s1),
		.pop_ready (m_axis_tready),
		.pop_valid (m_axis_tvalid),
		.pop_item  (out_item),
		.level     (fifo_level)
	);

	assign m_axis_tdata = {out_item.blue, out_item.green, out_item.red};
	assign m_axis_tlast = out_item.eof;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_used <= (CW + 1)'(OUT_FIFO_DEPTH))
		else $error("result buffer credit exceeded");

	a_eof_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl_now.eof |=> (in_col_q == '0) && (out_col_q == '0) && (out_row_q == '0))
		else $error("positions not restarted after frame end");

	a_eof_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctl_s1.eof |-> ctl_s1.lag)
		else $error("frame end flagged on an item without a result");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> (in_col_q <= w_last_q) && (out_col_q <= w_last_q))
		else $error("column position beyond configured width");

endmodule
`default_nettype wire

[tb/bayer_bilinear_demosaic_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bayer_bilinear_demosaic_core: a bursty stream driver, a stalling
// sink and a scoreboard that predicts every RGB result from the accepted Bayer samples.
// Depends on bbd_pkg and the RTL under hdl/.
module bayer_bilinear_demosaic_core_tb
	import bbd_pkg::*;
();

	localparam int unsigned MAX_W = DEF_MAX_WIDTH;
	localparam int unsigned MAX_H = DEF_MAX_HEIGHT;
	localparam int unsigned PIPE_SETTLE = 8;
	localparam int unsigned MAX_REPORTS = 40;
	localparam int unsigned RANDOM_ITEMS = 1600;

	typedef struct packed {
		logic       flush;
		logic [7:0] raw;
	} bayer_word_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_HOLD
	} sink_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;   // [7:0] raw_value
	logic                 s_axis_tuser = 1'b0; // [0] cmd
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;        // [7:0] red, [15:8] green, [23:16] blue
	logic                 m_axis_tlast;

	bayer_bilinear_demosaic_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Samples waiting for the driver and RGB results waiting for the sink.
	bayer_word_t raw_stream[$];
	rgb_item_t   rgb_expected[$];
	int unsigned mismatches = 0;

	// Shadow of the block: geometry registers, line stores, window and positions.
	logic [CFG_W-1:0] width_reg = RESET_DIM;
	logic [CFG_W-1:0] height_reg = RESET_DIM;
	logic [7:0]       upper_mem [MAX_W];
	logic [7:0]       middle_mem [MAX_W];
	logic [7:0]       win [3][3];
	int unsigned      in_row, in_col, out_row, out_col;

	function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned top);
		if (v < MIN_DIM) begin
			return MIN_DIM;
		end
		if (v > top) begin
			return top;
		end
		return 32'(v);
	endfunction

	task automatic restart_frame();
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				win[k][j] = '0;
			end
		end
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
	endtask

	// Advances the shadow by one accepted sample and queues the RGB result it completes.
	task automatic predict_rgb(input logic flush, input logic [7:0] raw);
		int unsigned w, h, x, r, c;
		int unsigned p [3][3];
		int unsigned ctr_v, horiz, vert, ortho, diag;
		logic [7:0]  px;
		logic        lag;
		rgb_item_t   o;
		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		px = flush ? 8'd0 : raw;
		x = in_col;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = upper_mem[x];
		win[1][2] = middle_mem[x];
		win[2][2] = px;
		upper_mem[x] = middle_mem[x];
		middle_mem[x] = px;
		lag = (in_row >= 2) || (in_row == 1 && x >= 1);
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (lag) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					p[k][j] = win[k][j];
				end
			end
			r = out_row;
			c = out_col;
			// Mirror reflection: neighbors outside the frame take the opposite side.
			for (int k = 0; k < 3; k++) begin
				if (r == 0) p[0][k] = p[2][k];
				if (r == h - 1) p[2][k] = p[0][k];
			end
			for (int k = 0; k < 3; k++) begin
				if (c == 0) p[k][0] = p[k][2];
				if (c == w - 1) p[k][2] = p[k][0];
			end
			ctr_v = p[1][1];
			horiz = (p[1][0] + p[1][2]) >> 1;
			vert = (p[0][1] + p[2][1]) >> 1;
			ortho = (p[0][1] + p[2][1] + p[1][0] + p[1][2]) >> 2;
			diag = (p[0][0] + p[0][2] + p[2][0] + p[2][2]) >> 2;
			if (r[0] == 1'b0 && c[0] == 1'b0) begin
				o.green = 8'(ctr_v); o.red = 8'(horiz); o.blue = 8'(vert);
			end else if (r[0] == 1'b0) begin
				o.red = 8'(ctr_v); o.green = 8'(ortho); o.blue = 8'(diag);
			end else if (c[0] == 1'b0) begin
				o.blue = 8'(ctr_v); o.green = 8'(ortho); o.red = 8'(diag);
			end else begin
				o.green = 8'(ctr_v); o.blue = 8'(horiz); o.red = 8'(vert);
			end
			o.eof = (r == h - 1) && (c == w - 1);
			rgb_expected.push_back(o);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
			if (o.eof) restart_frame();
		end
	endtask

	task automatic report(input string what, input int unsigned want, input int unsigned got);
		if (mismatches < MAX_REPORTS) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
		mismatches++;
	endtask

	// Scoreboard: input transfers feed the shadow, output transfers are checked in order.
	always @(posedge clk) begin : scoreboard
		rgb_item_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_rgb(s_axis_tuser, s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (rgb_expected.size() == 0) begin
					if (mismatches < MAX_REPORTS) begin
						$display("%0t: unexpected result, expected none, actual %h last %b",
							$time, m_axis_tdata, m_axis_tlast);
					end
					mismatches++;
				end else begin
					want = rgb_expected.pop_front();
					if (m_axis_tdata[7:0] !== want.red) report("red", want.red, m_axis_tdata[7:0]);
					if (m_axis_tdata[15:8] !== want.green) begin
						report("green", want.green, m_axis_tdata[15:8]);
					end
					if (m_axis_tdata[23:16] !== want.blue) begin
						report("blue", want.blue, m_axis_tdata[23:16]);
					end
					if (m_axis_tlast !== want.eof) report("end_of_frame", want.eof, m_axis_tlast);
				end
			end
		end
	end

	// Driver: bursts of random length separated by random gaps, occasionally long ones.
	bayer_word_t drv_word;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (raw_stream.size() > 0) begin
				drv_word = raw_stream.pop_front();
				s_axis_tdata <= drv_word.raw;
				s_axis_tuser <= drv_word.flush;
				s_axis_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					case ($urandom_range(0, 15))
						0: gap_left <= $urandom_range(12, 40);
						1, 2, 3, 4, 5, 6: gap_left <= 0;
						default: gap_left <= $urandom_range(1, 4);
					endcase
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Sink: switches between open, lightly stalled, heavily stalled and held stretches.
	sink_mode_t  sink_mode = RX_OPEN;
	int unsigned sink_span = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_mode <= RX_OPEN;
			sink_span <= 0;
		end else begin
			if (sink_span == 0) begin
				sink_mode <= sink_mode_t'($urandom_range(0, 3));
				sink_span <= $urandom_range(8, 150);
			end else begin
				sink_span <= sink_span - 1;
			end
			case (sink_mode)
				RX_OPEN:  m_axis_tready <= 1'b1;
				RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:  m_axis_tready <= 1'b0;
			endcase
		end
	end

	task automatic push_word(input logic flush, input logic [7:0] raw);
		bayer_word_t wd;
		wd.flush = flush;
		wd.raw = raw;
		raw_stream.push_back(wd);
	endtask

	// Returns once every sample is sent, every result is in and the pipeline has drained.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (raw_stream.size() != 0 || s_axis_tvalid || rgb_expected.size() != 0);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = val;
		end else begin
			height_reg = val;
		end
		restart_frame();
	endtask

	task automatic set_geometry(input bit wr_w, input bit wr_h, input bit h_first,
			input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
		wait_idle();
		if (wr_h && h_first) reg_write(REG_IMAGE_HEIGHT, h_val);
		if (wr_w) reg_write(REG_IMAGE_WIDTH, w_val);
		if (wr_h && !h_first) reg_write(REG_IMAGE_HEIGHT, h_val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Queues one frame plus its drain; a cut frame stops at a random point and
	// must be followed by a register write.
	task automatic queue_frame(input bit cut, output int unsigned count);
		int unsigned w, h, n_pix;
		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		n_pix = w * h;
		count = cut ? $urandom_range(1, n_pix + w) : n_pix + w + 1;
		for (int unsigned k = 0; k < count; k++) begin
			if (k < n_pix) begin
				push_word($urandom_range(0, 19) == 0, 8'($urandom));
			end else begin
				push_word($urandom_range(0, 9) != 0, 8'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		int unsigned fed, n, frames;
		logic [CFG_W-1:0] w_val, h_val;
		int unsigned which;
		restart_frame();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Smallest frame, widths below the minimum, extreme samples, a flush inside
		// the frame and a pixel among the drain items.
		set_geometry(1'b1, 1'b1, 1'b0, 13'd2, 13'd0);
		push_word(1'b0, 8'd255); push_word(1'b0, 8'd0);   push_word(1'b0, 8'd255);
		push_word(1'b0, 8'd0);   push_word(1'b0, 8'd255); push_word(1'b0, 8'd0);
		push_word(1'b0, 8'd255); push_word(1'b1, 8'd255); push_word(1'b0, 8'd255);
		push_word(1'b1, 8'd0);   push_word(1'b0, 8'h5A);  push_word(1'b1, 8'hFF);
		push_word(1'b1, 8'd0);
		// The next frame starts straight away and is cut short by a register write.
		push_word(1'b0, 8'd0);   push_word(1'b0, 8'd255); push_word(1'b0, 8'd128);
		push_word(1'b0, 8'd1);

		fed = 0;
		while (fed < RANDOM_ITEMS) begin
			w_val = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 2))
				: 13'($urandom_range(3, 24));
			h_val = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 2))
				: 13'($urandom_range(3, 9));
			which = (fed == 0) ? 2 : $urandom_range(0, 3);
			set_geometry(which != 1, which != 0, $urandom_range(0, 1), w_val, h_val);
			frames = $urandom_range(1, 3);
			for (int unsigned f = 0; f < frames; f++) begin
				queue_frame(f == frames - 1 && $urandom_range(0, 5) == 0, n);
				fed += n;
			end
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("PASS bayer_bilinear_demosaic_core");
		end else begin
			$display("FAIL bayer_bilinear_demosaic_core");
		end
		$finish;
	end

	initial begin : watchdog
		#20ms;
		$display("FAIL bayer_bilinear_demosaic_core");
		$finish;
	end

endmodule
